FILE: hw/rtl/signed_integer_to_decimal_text_defines.svh
// Assertion helpers shared by the RTL.
`ifndef SIGNED_INTEGER_TO_DECIMAL_TEXT_DEFINES_SVH
`define SIGNED_INTEGER_TO_DECIMAL_TEXT_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define SIDT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define SIDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/sidt_pkg.sv
package sidt_pkg;

    localparam int unsigned NumWidth   = 32;
    localparam int unsigned NumDigits  = 10;
    localparam int unsigned BcdWidth   = 4 * NumDigits;
    localparam int unsigned CharWidth  = 6;
    localparam int unsigned BitCntW    = $clog2(NumWidth);
    localparam int unsigned DigCntW    = $clog2(NumDigits + 1);

    localparam logic [CharWidth-1:0] AsciiZero  = CharWidth'(48);
    localparam logic [CharWidth-1:0] AsciiMinus = CharWidth'(45);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    // Add three to a BCD digit of five or more ahead of the doubling shift.
    function automatic logic [3:0] dabble(input logic [3:0] d);
        logic [3:0] r;
        begin
            if (d >= 4'd5)
            begin
                r = d + 4'd3;
            end
            else
            begin
                r = d;
            end
            return r;
        end
    endfunction

endpackage

FILE: hw/rtl/signed_integer_to_decimal_text.sv
// Channel  | Ports                  | Handshake
// ---------+------------------------+------------------------------------------
// input    | number                 | word taken when start is high, busy low
// output   | character, last_char   | strobe marks one word for one cycle
//
// The accepting edge loads the magnitude. The shift-add-3 BCD unit then converts it one
// binary bit at a time, and a second phase drops leading zeros one by one, keeping at
// least one digit, leaves the drop step and emits the digits. A negative number gets a
// minus sign ahead of the digits. Characters come back to back; busy drops as the last
// one is registered. Reset clears the sequencer and the strobe. The receiver cannot stall.
`include "signed_integer_to_decimal_text_defines.svh"

module signed_integer_to_decimal_text (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [31:0]            number,
    output logic                          busy,
    output logic                          strobe,
    output logic [5:0]                    character,
    output logic                          last_char
);
    import sidt_pkg::*;

    state_t                  state_reg, state_next;
    logic [NumWidth-1:0]     bin_reg, bin_next;
    logic [BcdWidth-1:0]     bcd_reg, bcd_next;
    logic [BitCntW-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [DigCntW-1:0]      dig_cnt_reg, dig_cnt_next;
    logic                    neg_reg, neg_next;
    logic                    strobe_reg, strobe_next;
    logic [CharWidth-1:0]    char_reg, char_next;
    logic                    last_reg, last_next;
    logic [BcdWidth-1:0]     bcd_adj;
    logic [3:0]              top_digit;

    always_comb
    begin
        for (int i = 0; i < NumDigits; i++)
        begin
            bcd_adj[4*i +: 4] = dabble(bcd_reg[4*i +: 4]);
        end
    end

    assign top_digit = bcd_reg[BcdWidth-1 -: 4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        neg_reg     <= neg_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        neg_next     = neg_reg;
        strobe_next  = 1'b0;
        char_next    = char_reg;
        last_next    = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    neg_next     = number[NumWidth-1];
                    bin_next     = number[NumWidth-1] ? (NumWidth'(0) - NumWidth'(number))
                                                      : NumWidth'(number);
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    dig_cnt_next = DigCntW'(NumDigits);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // adjust, then shift one binary bit into the BCD digits
                bcd_next     = {bcd_adj[BcdWidth-2:0], bin_reg[NumWidth-1]};
                bin_next     = {bin_reg[NumWidth-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BitCntW'(1);
                if (bit_cnt_reg == BitCntW'(NumWidth - 1))
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, keep at least one digit
                if ((top_digit == 4'd0) && (dig_cnt_reg != DigCntW'(1)))
                begin
                    bcd_next     = {bcd_reg[BcdWidth-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - DigCntW'(1);
                end
                else if (neg_reg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = AsciiMinus;
                last_next   = 1'b0;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                strobe_next  = 1'b1;
                char_next    = AsciiZero + CharWidth'(top_digit);
                last_next    = (dig_cnt_reg == DigCntW'(1));
                bcd_next     = {bcd_reg[BcdWidth-5:0], 4'd0};
                dig_cnt_next = dig_cnt_reg - DigCntW'(1);
                if (dig_cnt_reg == DigCntW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = strobe_reg;
    assign character = char_reg;
    assign last_char = strobe_reg & last_reg;

    `SIDT_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `SIDT_ASSERT_NOW(a_strobe_state, clk, rst_n, strobe,
        (state_reg == ST_EMIT) || (state_reg == ST_IDLE))
    `SIDT_ASSERT_NOW(a_last_idle, clk, rst_n, last_char, state_reg == ST_IDLE)
    `SIDT_ASSERT_NOW(a_char_code, clk, rst_n, strobe,
        (character == AsciiMinus) || ((character >= AsciiZero) &&
        (character <= AsciiZero + CharWidth'(9))))
    `SIDT_ASSERT_NOW(a_minus_not_last, clk, rst_n, strobe && (character == AsciiMinus),
        !last_char)

endmodule

FILE: tb/sv/decimal_text_checker.sv
`timescale 1ns / 1ps

module decimal_text_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic signed [sidt_pkg::NumWidth-1:0]  number,
    input  logic                                  strobe,
    input  logic [sidt_pkg::CharWidth-1:0]        character,
    input  logic                                  last_char,
    output int                                    errors,
    output int                                    pending
);
    import sidt_pkg::*;

    localparam int unsigned Radix = 10;

    typedef struct packed {
        logic [CharWidth-1:0] code;
        logic                 last;
    } text_char_t;

    text_char_t expected_text[$];

    function automatic void render_decimal(input logic [NumWidth-1:0] value);
        logic [NumWidth-1:0] mag;
        logic [3:0]          digit_buf [NumDigits];
        int                  ndig;
        mag  = value[NumWidth-1] ? (~value + 1'b1) : value;
        ndig = 0;
        do
        begin
            digit_buf[ndig] = 4'(mag % Radix);
            mag             = mag / Radix;
            ndig++;
        end
        while (mag != 0 && ndig < NumDigits);
        if (value[NumWidth-1])
        begin
            expected_text.push_back(text_char_t'{code: AsciiMinus, last: 1'b0});
        end
        for (int k = ndig - 1; k >= 0; k--)
        begin
            expected_text.push_back(text_char_t'{
                code: AsciiZero + CharWidth'(digit_buf[k]),
                last: (k == 0)});
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        text_char_t want;
        int         fails;
        if (!rst_n)
        begin
            expected_text.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            fails = 0;
            if (start && !busy)
            begin
                render_decimal(number);
            end
            if (strobe)
            begin
                if (expected_text.size() == 0)
                begin
                    $error("unexpected word: character %0d last_char %0b",
                           character, last_char);
                    fails++;
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (character !== want.code)
                    begin
                        $error("character: expected %0d, actual %0d", want.code, character);
                        fails++;
                    end
                    if (last_char !== want.last)
                    begin
                        $error("last_char: expected %0b, actual %0b", want.last, last_char);
                        fails++;
                    end
                end
            end
            errors  <= errors + fails;
            pending <= expected_text.size();
        end
    end

endmodule

FILE: tb/sv/tb_signed_integer_to_decimal_text.sv
`timescale 1ns / 1ps

module tb_signed_integer_to_decimal_text;

    import sidt_pkg::*;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        start;
    logic signed [NumWidth-1:0]  number;
    logic                        busy;
    logic                        strobe;
    logic [CharWidth-1:0]        character;
    logic                        last_char;
    int                          errors;
    int                          pending;
    int                          burst_left;

    signed_integer_to_decimal_text dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .number    (number),
        .busy      (busy),
        .strobe    (strobe),
        .character (character),
        .last_char (last_char)
    );

    decimal_text_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .number    (number),
        .strobe    (strobe),
        .character (character),
        .last_char (last_char),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Hold the word until the block takes it; idle a random gap first, none during a burst.
    task automatic send_number(input logic [NumWidth-1:0] value);
        int gap;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 17);
            if ($urandom_range(0, 9) == 0)
            begin
                burst_left = $urandom_range(4, 20);
            end
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        number <= value;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    function automatic logic [NumWidth-1:0] draw_number();
        logic [NumWidth-1:0] value;
        logic [NumWidth-1:0] scale;
        int                  kind;
        kind  = $urandom_range(0, 3);
        scale = 1;
        repeat ($urandom_range(0, 9)) scale = scale * 10;
        case (kind)
            0: value = $urandom;
            1: value = $urandom_range(0, 999);
            2: value = scale + $urandom_range(0, 2) - 1;
            default: value = (scale > 1) ? ($urandom % scale) : 0;
        endcase
        if (kind != 0 && $urandom_range(0, 1) == 1)
        begin
            value = ~value + 1'b1;
        end
        return value;
    endfunction

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        number     = '0;
        burst_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_number(32'sd0);
        send_number(32'sd1);
        send_number(-32'sd1);
        send_number(32'sd9);
        send_number(32'sd10);
        send_number(-32'sd10);
        send_number(32'sd99);
        send_number(32'sd100);
        send_number(32'sd5);
        send_number(-32'sd123);
        send_number(32'sd999999999);
        send_number(32'sd1000000000);
        send_number(-32'sd1000000000);
        send_number(-32'sd999999999);
        send_number(32'sd1234567890);
        send_number(32'sh7FFFFFFF);
        send_number(32'sh80000000);
        send_number(32'sh80000001);
        send_number(32'shFFFFFFFF);
        send_number(32'sh55555555);
        send_number(32'shAAAAAAAA);
        send_number(32'sd0);

        repeat (460) send_number(draw_number());

        start <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);

        if (errors == 0 && pending == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
